FILE: rtl/core/cbpg_pkg.sv
package cbpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int PITCH_BITS = 16;
  localparam int COLOR_BITS = 8;
  localparam int PIX_BITS   = 4 * COLOR_BITS;
  localparam int ADDR_BITS  = 28;

  // The quotient is found 4 bits per pipeline stage over a padded dividend.
  localparam int DIVD_BITS  = COORD_BITS + COLOR_BITS;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (DIVD_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NUM_BITS   = DIV_STAGES * DIV_STEPS;

  // Input register, operand stage, divider stages and output register.
  localparam int PIPE_LAT = DIV_STAGES + 3;

  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;
  localparam int REG_IDX_BITS = 2;

  localparam logic [REG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_PITCH  = 2'd2;

  localparam logic [COORD_BITS-1:0] WIDTH_RST  = COORD_BITS'(1280);
  localparam logic [COORD_BITS-1:0] HEIGHT_RST = COORD_BITS'(1024);
  localparam logic [PITCH_BITS-1:0] PITCH_RST  = PITCH_BITS'(5120);

  localparam logic [COLOR_BITS-1:0] ALPHA     = 8'hFF;
  localparam logic [COLOR_BITS-1:0] COLOR_ON  = 8'hFF;
  localparam logic [COLOR_BITS-1:0] COLOR_OFF = 8'h00;
  localparam logic [COLOR_BITS-1:0] RAMP_GB   = 8'h40;

  typedef enum logic [2:0] {
    BAR_RED,
    BAR_GREEN,
    BAR_BLUE,
    BAR_YELLOW,
    BAR_MAGENTA,
    BAR_CYAN,
    BAR_RAMP,
    BAR_GREY
  } bar_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pixel_req_t;

  typedef struct packed {
    logic [PIX_BITS-1:0]  pixel_word;
    logic [ADDR_BITS-1:0] byte_address;
  } pixel_res_t;

  function automatic logic [PIX_BITS-1:0] pack_pixel(input logic [COLOR_BITS-1:0] r,
                                                     input logic [COLOR_BITS-1:0] g,
                                                     input logic [COLOR_BITS-1:0] b);
    return {ALPHA, r, g, b};
  endfunction

endpackage

FILE: rtl/core/color_bar_pattern_generator.sv
// Channel   | Handshake                           | Payload
// ----------+-------------------------------------+---------------------------
// request   | start high, busy low                | pixel_req_i (x, y)
// result    | done_o strobe, one cycle            | pixel_res_o (word, address)
// registers | psel & penable & pwrite (pready=1)  | paddr, pwdata / prdata
//
// One request is taken every cycle; busy stays low. Each result passes the input register,
// the operand stage, the divider stages and the output register in that order; the pipelined
// restoring divider retires 4 quotient bits per stage.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// The receiver cannot stall, so results leave in request order with no backpressure.
module color_bar_pattern_generator (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  cbpg_pkg::pixel_req_t                    pixel_req_i,
  output logic                                    done_o,
  output cbpg_pkg::pixel_res_t                    pixel_res_o,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [cbpg_pkg::APB_AW-1:0]             paddr,
  input  logic [cbpg_pkg::APB_DW-1:0]             pwdata,
  output logic [cbpg_pkg::APB_DW-1:0]             prdata,
  output logic                                    pready
);
  import cbpg_pkg::*;

  localparam int BW = COORD_BITS + 3;

  typedef struct packed {
    bar_e                  bar;
    logic [COORD_BITS:0]   rem;
    logic [NUM_BITS-1:0]   num;
    logic [ADDR_BITS-1:0]  addr;
  } div_stage_t;

  logic [COORD_BITS-1:0] width_q, height_q;
  logic [PITCH_BITS-1:0] pitch_q;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic cfg_we;

  logic                              s1_vld_q;
  logic [COORD_BITS-1:0]             s1_x_q, s1_y_q;
  bar_e                              s1_bar_q, s1_bar_d;
  logic [COORD_BITS+PITCH_BITS-1:0]  s1_prod_q, s1_prod_d;

  logic [DIV_STAGES:0] vld_q;
  div_stage_t          st_q [DIV_STAGES+1];
  div_stage_t          st_d [DIV_STAGES+1];

  logic       done_q;
  pixel_res_t res_q, res_d;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      pitch_q  <= PITCH_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_WIDTH:  width_q  <= pwdata[COORD_BITS-1:0];
        REG_HEIGHT: height_q <= pwdata[COORD_BITS-1:0];
        REG_PITCH:  pitch_q  <= pwdata[PITCH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      REG_PITCH:  prdata = APB_DW'(pitch_q);
      default:    prdata = '0;
    endcase
  end

  // Bar boundaries (width*k)/8 are compared in parallel; the lowest bound above x wins.
  always_comb begin
    logic [BW-1:0] bound;
    s1_bar_d = BAR_GREY;
    for (int k = 7; k >= 1; k--) begin
      bound = ({3'b000, width_q} * BW'(k)) >> 3;
      if ({3'b000, pixel_req_i.pixel_x} < bound) begin
        s1_bar_d = bar_e'(3'(k - 1));
      end
    end
    s1_prod_d = (COORD_BITS+PITCH_BITS)'(pixel_req_i.pixel_y)
              * (COORD_BITS+PITCH_BITS)'(pitch_q);
  end

  // The ramp and the grey level share one divider; the bar picks the operands.
  always_comb begin
    div_stage_t            cur;
    logic [COORD_BITS-1:0] dv;
    logic [COORD_BITS:0]   trial;
    logic [DIVD_BITS-1:0]  coord255;
    logic [COORD_BITS-1:0] coord;

    coord    = (s1_bar_q == BAR_RAMP) ? s1_x_q : s1_y_q;
    coord255 = {coord, COLOR_BITS'(0)} - DIVD_BITS'(coord);
    st_d[0].bar  = s1_bar_q;
    st_d[0].rem  = '0;
    st_d[0].num  = NUM_BITS'(coord255);
    st_d[0].addr = ADDR_BITS'(s1_prod_q) + ADDR_BITS'({s1_x_q, 2'b00});

    for (int s = 1; s <= DIV_STAGES; s++) begin
      cur = st_q[s-1];
      dv  = (cur.bar == BAR_GREY) ? height_q : width_q;
      for (int j = 0; j < DIV_STEPS; j++) begin
        trial = {cur.rem[COORD_BITS-1:0], cur.num[NUM_BITS-1]};
        // A zero divisor always passes, so the quotient comes out all ones.
        if (trial >= {1'b0, dv}) begin
          cur.rem = trial - {1'b0, dv};
          cur.num = {cur.num[NUM_BITS-2:0], 1'b1};
        end else begin
          cur.rem = trial;
          cur.num = {cur.num[NUM_BITS-2:0], 1'b0};
        end
      end
      st_d[s] = cur;
    end
  end

  always_comb begin
    logic [COLOR_BITS-1:0] lvl;
    lvl = st_q[DIV_STAGES].num[COLOR_BITS-1:0];
    res_d.byte_address = st_q[DIV_STAGES].addr;
    case (st_q[DIV_STAGES].bar)
      BAR_RED:     res_d.pixel_word = pack_pixel(COLOR_ON, COLOR_OFF, COLOR_OFF);
      BAR_GREEN:   res_d.pixel_word = pack_pixel(COLOR_OFF, COLOR_ON, COLOR_OFF);
      BAR_BLUE:    res_d.pixel_word = pack_pixel(COLOR_OFF, COLOR_OFF, COLOR_ON);
      BAR_YELLOW:  res_d.pixel_word = pack_pixel(COLOR_ON, COLOR_ON, COLOR_OFF);
      BAR_MAGENTA: res_d.pixel_word = pack_pixel(COLOR_ON, COLOR_OFF, COLOR_ON);
      BAR_CYAN:    res_d.pixel_word = pack_pixel(COLOR_OFF, COLOR_ON, COLOR_ON);
      BAR_RAMP:    res_d.pixel_word = pack_pixel(lvl, RAMP_GB, RAMP_GB);
      default:     res_d.pixel_word = pack_pixel(lvl, lvl, lvl);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      vld_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= start && !busy;
      vld_q    <= {vld_q[DIV_STAGES-1:0], s1_vld_q};
      done_q   <= vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_x_q    <= pixel_req_i.pixel_x;
    s1_y_q    <= pixel_req_i.pixel_y;
    s1_bar_q  <= s1_bar_d;
    s1_prod_q <= s1_prod_d;
    for (int s = 0; s <= DIV_STAGES; s++) begin
      st_q[s] <= st_d[s];
    end
    res_q <= res_d;
  end

  assign done_o      = done_q;
  assign pixel_res_o = res_q;

endmodule

FILE: rtl/core/cbpg_checker.sv
module cbpg_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input cbpg_pkg::pixel_res_t        pixel_res_o,
  input logic                        pready
);
  import cbpg_pkg::*;

  // Every request comes back after the fixed pipeline latency.
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PIPE_LAT done_o)
    else $error("request did not produce a result after the pipeline latency");

  // No result appears without a request the pipeline latency earlier.
  a_latency_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching request");

  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pixel_res_o.pixel_word[PIX_BITS-1 -: COLOR_BITS] == ALPHA))
    else $error("pixel alpha is not opaque");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && !busy)
    else $error("register port or request side stalled");

endmodule

bind color_bar_pattern_generator cbpg_checker u_cbpg_checker (.*);

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cbpg_pkg::*;

  localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    pixel_req_t req;
    logic       known;
    pixel_res_t res;
  } pixel_vec_t;

  typedef struct packed {
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] pitch;
  } frame_cfg_t;

  // Directed requests under the reset geometry of 1280 x 1024 with a 5120-byte pitch.
  localparam int NUM_DIRECTED = 18;
  localparam pixel_vec_t DIRECTED_PIXELS [NUM_DIRECTED] = '{
    '{'{12'd0,    12'd0},    1'b1, '{32'hFFFF0000, 28'd0}},
    '{'{12'd159,  12'd0},    1'b1, '{32'hFFFF0000, 28'd636}},
    '{'{12'd160,  12'd0},    1'b1, '{32'hFF00FF00, 28'd640}},
    '{'{12'd320,  12'd0},    1'b1, '{32'hFF0000FF, 28'd1280}},
    '{'{12'd480,  12'd0},    1'b1, '{32'hFFFFFF00, 28'd1920}},
    '{'{12'd640,  12'd0},    1'b1, '{32'hFFFF00FF, 28'd2560}},
    '{'{12'd800,  12'd0},    1'b1, '{32'hFF00FFFF, 28'd3200}},
    '{'{12'd960,  12'd0},    1'b1, '{32'hFFBF4040, 28'd3840}},
    '{'{12'd1119, 12'd0},    1'b1, '{32'hFFDE4040, 28'd4476}},
    '{'{12'd1120, 12'd0},    1'b1, '{32'hFF000000, 28'd4480}},
    '{'{12'd1279, 12'd1023}, 1'b1, '{32'hFFFEFEFE, 28'd5242876}},
    '{'{12'd4095, 12'd4095}, 1'b1, '{32'hFFFBFBFB, 28'd20982780}},
    '{'{12'd4095, 12'd0},    1'b0, '0},
    '{'{12'd0,    12'd4095}, 1'b0, '0},
    '{'{12'd2048, 12'd2048}, 1'b0, '0},
    '{'{12'd1200, 12'd1024}, 1'b0, '0},
    '{'{12'hAAA,  12'h555},  1'b0, '0},
    '{'{12'h555,  12'hAAA},  1'b0, '0}
  };

  // Fixed geometries for the first phases; upper bits beyond each register are set on purpose in the last one.
  localparam frame_cfg_t FIXED_GEOMETRY [4] = '{
    '{32'd4095,      32'd4095,      32'd65535},
    '{32'd1,         32'd1,         32'd0},
    '{32'd0,         32'd0,         32'h0000_1234},
    '{32'hFFFF_F008, 32'h0000_3003, 32'hABCD_0100}
  };

  localparam int SENDER_IDLE_PCT [NUM_PHASES] = '{0, 69, 0, 38, 0, 69, 0, 38};

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  pixel_req_t              pixel_req_i = '0;
  logic                    done_o;
  pixel_res_t              pixel_res_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_AW-1:0]       paddr = '0;
  logic [APB_DW-1:0]       pwdata = '0;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;

  logic                    known_valid_q = 1'b0;
  pixel_res_t              known_res_q = '0;

  logic [COORD_BITS-1:0]   cfg_width = WIDTH_RST;
  logic [COORD_BITS-1:0]   cfg_height = HEIGHT_RST;
  logic [PITCH_BITS-1:0]   cfg_pitch = PITCH_RST;

  pixel_res_t              due_pixels [$];
  pixel_res_t              oldest_due;
  int                      errors = 0;
  int                      quiet_cycles = 0;

  color_bar_pattern_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pixel_req_i (pixel_req_i),
    .done_o      (done_o),
    .pixel_res_o (pixel_res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic pixel_res_t pattern_pixel(input pixel_req_t r);
    int unsigned     x;
    int unsigned     y;
    int unsigned     w;
    int unsigned     h;
    logic [COLOR_BITS-1:0] lvl;
    bar_e            bar;
    pixel_res_t      res;
    x = 32'(r.pixel_x);
    y = 32'(r.pixel_y);
    w = 32'(cfg_width);
    h = 32'(cfg_height);
    if (x < w / 8) bar = BAR_RED;
    else if (x < (w * 2) / 8) bar = BAR_GREEN;
    else if (x < (w * 3) / 8) bar = BAR_BLUE;
    else if (x < (w * 4) / 8) bar = BAR_YELLOW;
    else if (x < (w * 5) / 8) bar = BAR_MAGENTA;
    else if (x < (w * 6) / 8) bar = BAR_CYAN;
    else if (x < (w * 7) / 8) bar = BAR_RAMP;
    else bar = BAR_GREY;
    case (bar)
      BAR_RED:     res.pixel_word = {ALPHA, COLOR_ON, COLOR_OFF, COLOR_OFF};
      BAR_GREEN:   res.pixel_word = {ALPHA, COLOR_OFF, COLOR_ON, COLOR_OFF};
      BAR_BLUE:    res.pixel_word = {ALPHA, COLOR_OFF, COLOR_OFF, COLOR_ON};
      BAR_YELLOW:  res.pixel_word = {ALPHA, COLOR_ON, COLOR_ON, COLOR_OFF};
      BAR_MAGENTA: res.pixel_word = {ALPHA, COLOR_ON, COLOR_OFF, COLOR_ON};
      BAR_CYAN:    res.pixel_word = {ALPHA, COLOR_OFF, COLOR_ON, COLOR_ON};
      BAR_RAMP: begin
        // The ramp bar can only be reached with a nonzero width.
        lvl = COLOR_BITS'((x * 255) / w);
        res.pixel_word = {ALPHA, lvl, RAMP_GB, RAMP_GB};
      end
      default: begin
        // A zero height makes the divider answer all ones.
        lvl = (h != 0) ? COLOR_BITS'((y * 255) / h) : 8'hFF;
        res.pixel_word = {ALPHA, lvl, lvl, lvl};
      end
    endcase
    res.byte_address = ADDR_BITS'(64'(y) * 64'(cfg_pitch) + 64'(x) * 64'd4);
    return res;
  endfunction

  // Results are checked before the new request is queued, since they belong to older requests.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (due_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word %h address %h", $time,
                   pixel_res_o.pixel_word, pixel_res_o.byte_address);
        end else begin
          oldest_due = due_pixels.pop_front();
          if (pixel_res_o.pixel_word !== oldest_due.pixel_word) begin
            errors++;
            $display("%0t: pixel_word expected %h actual %h", $time,
                     oldest_due.pixel_word, pixel_res_o.pixel_word);
          end
          if (pixel_res_o.byte_address !== oldest_due.byte_address) begin
            errors++;
            $display("%0t: byte_address expected %h actual %h", $time,
                     oldest_due.byte_address, pixel_res_o.byte_address);
          end
        end
      end
      if (start && !busy) begin
        due_pixels.push_back(known_valid_q ? known_res_q : pattern_pixel(pixel_req_i));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_WIDTH:  cfg_width <= pwdata[COORD_BITS-1:0];
          REG_HEIGHT: cfg_height <= pwdata[COORD_BITS-1:0];
          REG_PITCH:  cfg_pitch <= pwdata[PITCH_BITS-1:0];
          default: ;
        endcase
      end
      if (done_o || (start && !busy) || (psel && penable && pwrite && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  task automatic send_pixel(input pixel_req_t r, input logic known, input pixel_res_t res,
                            input int idle_pct);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    pixel_req_i <= r;
    known_valid_q <= known;
    known_res_q <= res;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
  endtask

  // Holds requests off until every queued pixel has come back.
  task automatic wait_pixels_done();
    start <= 1'b0;
    do @(negedge clk_i); while (due_pixels.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [APB_DW-1:0] val);
    logic rdy;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    rdy = 1'b0;
    while (!rdy) begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // The bus idles before the next transfer.
    @(posedge clk_i);
  endtask

  initial begin
    frame_cfg_t  geo;
    pixel_req_t  req;
    int unsigned cur_w;
    int unsigned bound;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_PIXELS[i]) begin
      send_pixel(DIRECTED_PIXELS[i].req, DIRECTED_PIXELS[i].known, DIRECTED_PIXELS[i].res, 0);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_pixels_done();
      if (ph < 4) begin
        geo = FIXED_GEOMETRY[ph];
      end else begin
        // Narrow frames half the time so the bar boundaries get hit often, full-range ones otherwise.
        geo.width = ($urandom_range(1) == 0) ? $urandom : $urandom_range(1, 64);
        geo.height = ($urandom_range(1) == 0) ? $urandom : $urandom_range(1, 64);
        geo.pitch = $urandom;
      end
      write_reg(REG_WIDTH, geo.width);
      write_reg(REG_HEIGHT, geo.height);
      write_reg(REG_PITCH, geo.pitch);
      write_reg(REG_SPARE, $urandom);
      cur_w = 32'(geo.width[COORD_BITS-1:0]);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) wait_pixels_done();
        req.pixel_y = COORD_BITS'($urandom);
        case ($urandom_range(3))
          0: req.pixel_x = COORD_BITS'($urandom);
          3: begin
            bound = (cur_w * $urandom_range(1, 7)) / 8;
            req.pixel_x = COORD_BITS'(bound - $urandom_range(1));
          end
          default: req.pixel_x = (cur_w == 0) ? COORD_BITS'($urandom)
                                              : COORD_BITS'($urandom_range(cur_w));
        endcase
        send_pixel(req, 1'b0, '0, SENDER_IDLE_PCT[ph]);
      end
    end

    wait_pixels_done();
    repeat (PIPE_LAT + 4) @(posedge clk_i);
    if (due_pixels.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, due_pixels.size());
    end
    if (errors == 0 && due_pixels.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
